>>> rtl/pfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants of the point frame parser with proximity counter.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIST_W  = 17;
  localparam int unsigned NEAR_W  = 12;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CNT_W   = 5;

  // point list geometry
  localparam int unsigned LIST_DEPTH = 8;
  localparam int unsigned LIST_IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // framing constants
  localparam logic [BYTE_W-1:0] FRAME_END       = 8'd255;
  localparam logic [CNT_W:0]    FRAME_MIN_BYTES = 6'd5;
  localparam logic [CNT_W:0]    RESYNC_COUNT    = 6'd20;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIST_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT_SQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_WRAP     = 2'd2;

  // receive modes
  localparam logic MODE_LIST     = 1'b0;
  localparam logic MODE_FEEDBACK = 1'b1;

  // register reset values
  localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 17'd50;
  localparam logic [NEAR_W-1:0] NEAR_WRAP_RST  = 12'd3000;

  // one result item
  typedef struct packed {
    logic              frame_done;
    logic [BYTE_W-1:0] red_x_out;
    logic [BYTE_W-1:0] red_y_out;
    logic [BYTE_W-1:0] green_x_out;
    logic [BYTE_W-1:0] green_y_out;
    logic              near_now;
    logic [NEAR_W-1:0] near_count_out;
    logic              list_written;
    logic [SLOT_W-1:0] list_slot;
  } result_t;

  // control from the input stage to the step logic
  typedef struct packed {
    logic              step;
    logic [BYTE_W-1:0] rx_byte;
  } step_t;

endpackage

>>> rtl/pfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_in_if / pfp_out_if
// Valid/ready channels carrying received bytes and result items.
// ----------------------------------------------------------------------------
interface pfp_in_if;
  logic                       valid;
  logic                       ready;
  logic [pfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_done;
  logic [pfp_pkg::BYTE_W-1:0] red_x_out;
  logic [pfp_pkg::BYTE_W-1:0] red_y_out;
  logic [pfp_pkg::BYTE_W-1:0] green_x_out;
  logic [pfp_pkg::BYTE_W-1:0] green_y_out;
  logic                       near_now;
  logic [pfp_pkg::NEAR_W-1:0] near_count_out;
  logic                       list_written;
  logic [pfp_pkg::SLOT_W-1:0] list_slot;

  modport source (output valid, output frame_done, output red_x_out, output red_y_out,
                  output green_x_out, output green_y_out, output near_now,
                  output near_count_out, output list_written, output list_slot,
                  input ready);
  modport sink   (input valid, input frame_done, input red_x_out, input red_y_out,
                  input green_x_out, input green_y_out, input near_now,
                  input near_count_out, input list_written, input list_slot,
                  output ready);
endinterface

>>> rtl/point_frame_parser_proximity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_frame_parser_proximity_unit
// Byte stream parser: point list writer and feedback frame proximity counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries received bytes, out_o carries one result item per byte, both
//   valid/ready. cfg_we_i/cfg_idx_i/cfg_data_i write the mode, the squared
//   distance limit and the near counter wrap value; write them while idle.
//   An accepted item lands in an input register; when the result register is
//   free or being taken, the whole step (two 8x8 squares, add, compare) runs
//   and loads the result register. One item per cycle sustained while out_o
//   takes every result; the step is combinational between the two registers.
//   When out_o stalls, the result register holds; the input register takes one
//   more item, then in_i.ready drops until the result is taken.
//   Reset clears both stages, all parser state and restores register defaults
//   (list mode, limit 50, wrap 3000). Point list contents stay undefined.
// ----------------------------------------------------------------------------
module point_frame_parser_proximity_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pfp_in_if.sink                         in_i,
  pfp_out_if.source                      out_o
);

  logic                       in_vld_q;
  logic [pfp_pkg::BYTE_W-1:0] in_byte_q;
  logic                       out_vld_q;
  pfp_pkg::result_t           res_d, res_q;
  pfp_pkg::step_t             step;
  logic                       advance;

  // pipeline flow
  assign advance    = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || advance;

  assign step.step    = in_vld_q && advance;
  assign step.rx_byte = in_byte_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.rx_byte;
    end
  end

  pfp_proc u_proc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .result_o   (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.step) begin
      res_q <= res_d;
    end
  end

  // output drive
  assign out_o.valid          = out_vld_q;
  assign out_o.frame_done     = res_q.frame_done;
  assign out_o.red_x_out      = res_q.red_x_out;
  assign out_o.red_y_out      = res_q.red_y_out;
  assign out_o.green_x_out    = res_q.green_x_out;
  assign out_o.green_y_out    = res_q.green_y_out;
  assign out_o.near_now       = res_q.near_now;
  assign out_o.near_count_out = res_q.near_count_out;
  assign out_o.list_written   = res_q.list_written;
  assign out_o.list_slot      = res_q.list_slot;

endmodule

>>> rtl/pfp_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_dist
// Squared distance between the red and green points, two squares in parallel.
// ----------------------------------------------------------------------------
module pfp_dist (
  input  logic [pfp_pkg::BYTE_W-1:0] red_x_i,
  input  logic [pfp_pkg::BYTE_W-1:0] red_y_i,
  input  logic [pfp_pkg::BYTE_W-1:0] green_x_i,
  input  logic [pfp_pkg::BYTE_W-1:0] green_y_i,
  output logic [pfp_pkg::DIST_W-1:0] dist_o
);

  logic [pfp_pkg::BYTE_W-1:0]   dx, dy;
  logic [2*pfp_pkg::BYTE_W-1:0] dx_sq, dy_sq;

  // absolute differences
  assign dx = (red_x_i >= green_x_i) ? (red_x_i - green_x_i) : (green_x_i - red_x_i);
  assign dy = (red_y_i >= green_y_i) ? (red_y_i - green_y_i) : (green_y_i - red_y_i);

  // squares and sum
  assign dx_sq  = dx * dx;
  assign dy_sq  = dy * dy;
  assign dist_o = {1'b0, dx_sq} + {1'b0, dy_sq};

endmodule

>>> rtl/pfp_proc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_proc
// Configuration registers, parser state and next result for one byte.
// ----------------------------------------------------------------------------
module pfp_proc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  pfp_pkg::step_t                step_i,
  output pfp_pkg::result_t              result_o
);

  localparam int unsigned BW = pfp_pkg::BYTE_W;
  localparam int unsigned NW = pfp_pkg::NEAR_W;
  localparam int unsigned CW = pfp_pkg::CNT_W;
  localparam int unsigned IW = pfp_pkg::LIST_IDX_W;

  // configuration registers
  logic                      mode_q;
  logic [pfp_pkg::DIST_W-1:0] limit_q;
  logic [NW-1:0]             wrap_q;

  // parser state
  logic [CW-1:0] byte_count_q, byte_count_d;
  logic [BW-1:0] recent_q [4];
  logic [BW-1:0] coords_q [4];
  logic [IW-1:0] list_idx_q, list_idx_d;
  logic [NW-1:0] near_count_q, near_count_d;
  logic          near_flag_q, near_flag_d;
  logic [BW-1:0] point_list [pfp_pkg::LIST_DEPTH];

  logic [pfp_pkg::DIST_W-1:0] sq_dist;
  logic [CW:0]   cnt_inc, cnt_next;
  logic [NW:0]   near_inc;
  logic          feedback, frame;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pfp_pkg::MODE_LIST;
      limit_q <= pfp_pkg::NEAR_LIMIT_RST;
      wrap_q  <= pfp_pkg::NEAR_WRAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfp_pkg::CFG_RECEIVE_MODE:  mode_q  <= cfg_data_i[0];
        pfp_pkg::CFG_NEAR_LIMIT_SQ: limit_q <= cfg_data_i[pfp_pkg::DIST_W-1:0];
        pfp_pkg::CFG_NEAR_WRAP:     wrap_q  <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  // distance of the four bytes that a frame end would latch
  pfp_dist u_dist (
    .red_x_i   (recent_q[0]),
    .red_y_i   (recent_q[1]),
    .green_x_i (recent_q[2]),
    .green_y_i (recent_q[3]),
    .dist_o    (sq_dist)
  );

  assign feedback = (mode_q == pfp_pkg::MODE_FEEDBACK);
  assign cnt_inc  = {1'b0, byte_count_q} + 1'b1;
  assign frame    = feedback && (cnt_inc >= pfp_pkg::FRAME_MIN_BYTES) &&
                    (step_i.rx_byte == pfp_pkg::FRAME_END);
  assign near_inc = {1'b0, near_count_q} + 1'b1;

  // next state of counters and flag
  always_comb begin
    cnt_next     = frame ? '0 : cnt_inc;
    if (cnt_next >= pfp_pkg::RESYNC_COUNT) begin
      cnt_next = '0;
    end
    byte_count_d = feedback ? cnt_next[CW-1:0] : byte_count_q;

    near_flag_d  = near_flag_q;
    near_count_d = near_count_q;
    if (frame) begin
      if (sq_dist <= limit_q) begin
        near_flag_d  = 1'b1;
        near_count_d = (near_inc >= {1'b0, wrap_q}) ? '0 : near_inc[NW-1:0];
      end else begin
        near_flag_d  = 1'b0;
        near_count_d = '0;
      end
    end

    list_idx_d = (list_idx_q == IW'(pfp_pkg::LIST_DEPTH - 1)) ? '0 : list_idx_q + 1'b1;
  end

  // state update on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      list_idx_q   <= '0;
      near_count_q <= '0;
      near_flag_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        recent_q[i] <= '0;
        coords_q[i] <= '0;
      end
    end else if (step_i.step) begin
      if (feedback) begin
        byte_count_q <= byte_count_d;
        near_count_q <= near_count_d;
        near_flag_q  <= near_flag_d;
        recent_q[0]  <= recent_q[1];
        recent_q[1]  <= recent_q[2];
        recent_q[2]  <= recent_q[3];
        recent_q[3]  <= step_i.rx_byte;
        if (frame) begin
          for (int i = 0; i < 4; i++) begin
            coords_q[i] <= recent_q[i];
          end
        end
      end else begin
        list_idx_q <= list_idx_d;
      end
    end
  end

  // point list storage
  always_ff @(posedge clk_i) begin
    if (step_i.step && !feedback) begin
      point_list[list_idx_q] <= step_i.rx_byte;
    end
  end

  // result for the byte being processed
  always_comb begin
    result_o.frame_done     = frame;
    result_o.red_x_out      = frame ? recent_q[0] : coords_q[0];
    result_o.red_y_out      = frame ? recent_q[1] : coords_q[1];
    result_o.green_x_out    = frame ? recent_q[2] : coords_q[2];
    result_o.green_y_out    = frame ? recent_q[3] : coords_q[3];
    result_o.near_now       = near_flag_d;
    result_o.near_count_out = near_count_d;
    result_o.list_written   = !feedback;
    result_o.list_slot      = feedback ? '0 : pfp_pkg::SLOT_W'(list_idx_q);
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point frame parser with proximity counter.
// A directed table covers list wrap, short and full frames and extreme
// coordinates. Random phases follow, each under its own mode, distance limit
// and wrap value, with mostly well-formed frames plus noise and long runs.
// Every result item is checked against a table entry or a cycle-free model.
// ----------------------------------------------------------------------------
module tb;
  import pfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int NUM_PHASES = 9;

  // one row of the directed table: a register write or a byte
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  typed;
    result_t               want;
  } stim_row_t;

  // register settings of one random phase
  typedef struct packed {
    logic                  mode;
    logic [CFG_DATA_W-1:0] limit;
    logic [CFG_DATA_W-1:0] wrap_word;
    logic [10:0]           n_items;
  } phase_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pfp_in_if  byte_if ();
  pfp_out_if res_if ();

  point_frame_parser_proximity_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_if),
    .out_o      (res_if)
  );

  // parser state as the bench sees it
  logic                  m_mode;
  logic [DIST_W-1:0]     m_limit;
  logic [NEAR_W-1:0]     m_wrap;
  logic [CNT_W-1:0]      m_byte_cnt;
  logic [BYTE_W-1:0]     m_recent [4];
  logic [SLOT_W-1:0]     m_list_idx;
  logic [NEAR_W-1:0]     m_near_cnt;
  logic [BYTE_W-1:0]     m_coords [4];
  logic                  m_near;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  phase_t    phases [NUM_PHASES];

  int  mismatches;
  int  bytes_sent;
  int  frames_seen;
  int  list_seen;
  int  results_seen;
  int  hold_len;
  int  hold_at_item;
  int  holds_done;
  bit  calm;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // overall time limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // register write into the bench state, masked to register width
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RECEIVE_MODE:  m_mode  = data[0];
      CFG_NEAR_LIMIT_SQ: m_limit = data[DIST_W-1:0];
      CFG_NEAR_WRAP:     m_wrap  = data[NEAR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int sq_gap(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    int d;
    d = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d * d;
  endfunction

  // one received byte: update the parser state and form its result item
  function automatic result_t parse_byte(logic [BYTE_W-1:0] b);
    result_t r;
    logic [CNT_W:0] cnt;
    logic [NEAR_W:0] nc;
    int sq_dist;
    r = '0;
    if (m_mode == MODE_LIST) begin
      r.list_written = 1'b1;
      r.list_slot    = m_list_idx;
      m_list_idx     = (int'(m_list_idx) + 1 >= LIST_DEPTH) ? '0 : m_list_idx + 1'b1;
    end else begin
      cnt = {1'b0, m_byte_cnt} + 1'b1;
      if (cnt >= FRAME_MIN_BYTES && b == FRAME_END) begin
        for (int k = 0; k < 4; k++) m_coords[k] = m_recent[k];
        cnt          = '0;
        r.frame_done = 1'b1;
        sq_dist = sq_gap(m_coords[0], m_coords[2]) + sq_gap(m_coords[1], m_coords[3]);
        if (sq_dist <= int'(m_limit)) begin
          m_near = 1'b1;
          nc = {1'b0, m_near_cnt} + 1'b1;
          if (nc >= {1'b0, m_wrap}) nc = '0;
          m_near_cnt = nc[NEAR_W-1:0];
        end else begin
          m_near     = 1'b0;
          m_near_cnt = '0;
        end
      end
      if (cnt >= RESYNC_COUNT) cnt = '0;
      m_byte_cnt = cnt[CNT_W-1:0];
      m_recent[0] = m_recent[1];
      m_recent[1] = m_recent[2];
      m_recent[2] = m_recent[3];
      m_recent[3] = b;
    end
    r.red_x_out      = m_coords[0];
    r.red_y_out      = m_coords[1];
    r.green_x_out    = m_coords[2];
    r.green_y_out    = m_coords[3];
    r.near_now       = m_near;
    r.near_count_out = m_near_cnt;
    return r;
  endfunction

  function automatic result_t res(logic f, logic [7:0] rx, logic [7:0] ry, logic [7:0] gx,
                                  logic [7:0] gy, logic nn, logic [11:0] nc, logic w,
                                  logic [2:0] s);
    result_t r;
    r = {f, rx, ry, gx, gy, nn, nc, w, s};
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b, logic typed, result_t want);
    stim_row_t row;
    row = '0;
    row.rx_byte = b;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  // coordinate with weight on the extremes
  function automatic logic [7:0] pick_coord();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // coordinate close to another one
  function automatic logic [7:0] nudge(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 14)) - 7;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  // offer one item and record its expected result on acceptance
  task automatic send_byte(logic [7:0] b, logic typed, result_t want);
    int gap;
    result_t r;
    if (bytes_sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i) byte_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i) begin
      byte_if.valid   <= 1'b1;
      byte_if.rx_byte <= b;
    end
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    r = parse_byte(b);
    pending_results.push_back(typed ? want : r);
    bytes_sent++;
    if (bytes_sent == hold_at_item) hold_len = 80;
  endtask

  // stop offering and wait until the block has nothing in flight
  task automatic settle();
    @(negedge clk_i) byte_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
    end
    @(negedge clk_i) cfg_we_i <= 1'b0;
    apply_cfg(idx, data);
  endtask

  // feedback traffic: mostly frames, some noise, long runs and cut frames
  task automatic run_feedback(int n);
    int sent;
    int kind;
    int len;
    logic [7:0] c [4];
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        c[0] = pick_coord();
        c[1] = pick_coord();
        if ($urandom_range(0, 1) == 1) begin
          c[2] = nudge(c[0]);
          c[3] = nudge(c[1]);
        end else begin
          c[2] = pick_coord();
          c[3] = pick_coord();
        end
        for (int k = 0; k < 4; k++) send_byte(c[k], 1'b0, '0);
        send_byte(FRAME_END, 1'b0, '0);
        sent += 5;
      end else if (kind == 7) begin
        len = $urandom_range(1, 8);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        sent += len;
      end else if (kind == 8) begin
        // no frame end for a while, so the count can resynchronize
        len = $urandom_range(18, 25);
        repeat (len) send_byte(8'($urandom_range(0, 254)), 1'b0, '0);
        sent += len;
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) send_byte(pick_coord(), 1'b0, '0);
        send_byte(FRAME_END, 1'b0, '0);
        sent += len + 1;
      end
    end
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int w;
    res_if.ready = 1'b0;
    forever begin
      if (hold_len > 0) begin
        @(negedge clk_i) res_if.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
        hold_len = 0;
        holds_done++;
      end
      w = calm ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        @(negedge clk_i) res_if.ready <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
      end
      @(negedge clk_i) res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.frame_done, res_if.red_x_out, res_if.red_y_out, res_if.green_x_out,
             res_if.green_y_out, res_if.near_now, res_if.near_count_out,
             res_if.list_written, res_if.list_slot};
      results_seen++;
      if (got.frame_done === 1'b1) frames_seen++;
      if (got.list_written === 1'b1) list_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %0d: %p", results_seen, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  exp: frame %0b red %0d,%0d green %0d,%0d near %0b cnt %0d wr %0b slot %0d",
                     want.frame_done, want.red_x_out, want.red_y_out, want.green_x_out,
                     want.green_y_out, want.near_now, want.near_count_out,
                     want.list_written, want.list_slot);
            $display("  got: frame %0b red %0d,%0d green %0d,%0d near %0b cnt %0d wr %0b slot %0d",
                     got.frame_done, got.red_x_out, got.red_y_out, got.green_x_out,
                     got.green_y_out, got.near_now, got.near_count_out,
                     got.list_written, got.list_slot);
          end
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int waited;
    stim_row_t row;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = '0;
    mismatches      = 0;
    bytes_sent      = 0;
    frames_seen     = 0;
    list_seen       = 0;
    results_seen    = 0;
    hold_len        = 0;
    hold_at_item    = -1;
    holds_done      = 0;
    calm            = 1'b0;

    // bench state after reset
    m_mode     = MODE_LIST;
    m_limit    = NEAR_LIMIT_RST;
    m_wrap     = NEAR_WRAP_RST;
    m_byte_cnt = '0;
    m_list_idx = '0;
    m_near_cnt = '0;
    m_near     = 1'b0;
    for (int k = 0; k < 4; k++) begin
      m_recent[k] = '0;
      m_coords[k] = '0;
    end

    // directed table
    directed_rows.push_back(byte_row(8'h00, 1'b1, res(0, 0, 0, 0, 0, 0, 0, 1, 0)));
    directed_rows.push_back(byte_row(FRAME_END, 1'b0, '0));
    directed_rows.push_back(byte_row(8'h01, 1'b0, '0));
    directed_rows.push_back(byte_row(8'h80, 1'b0, '0));
    directed_rows.push_back(byte_row(8'hAA, 1'b0, '0));
    directed_rows.push_back(byte_row(8'h55, 1'b0, '0));
    directed_rows.push_back(byte_row(8'h7F, 1'b0, '0));
    directed_rows.push_back(byte_row(8'hFE, 1'b0, '0));
    // list index wraps back to the first entry
    directed_rows.push_back(byte_row(8'h3C, 1'b1, res(0, 0, 0, 0, 0, 0, 0, 1, 0)));
    directed_rows.push_back(cfg_row(CFG_UNUSED_IDX, 17'h1FFFF));
    directed_rows.push_back(cfg_row(CFG_RECEIVE_MODE, 17'(MODE_FEEDBACK)));
    directed_rows.push_back(byte_row(8'd10, 1'b0, '0));
    directed_rows.push_back(byte_row(8'd20, 1'b0, '0));
    directed_rows.push_back(byte_row(8'd13, 1'b0, '0));
    directed_rows.push_back(byte_row(8'd24, 1'b0, '0));
    directed_rows.push_back(byte_row(FRAME_END, 1'b1, res(1, 10, 20, 13, 24, 1, 1, 0, 0)));
    // frame end bytes too soon after a frame
    repeat (4) directed_rows.push_back(byte_row(FRAME_END, 1'b0, '0));
    directed_rows.push_back(byte_row(FRAME_END, 1'b1, res(1, 255, 255, 255, 255, 1, 2, 0, 0)));
    // largest distance clears the counter
    directed_rows.push_back(byte_row(8'd0, 1'b0, '0));
    directed_rows.push_back(byte_row(8'd0, 1'b0, '0));
    directed_rows.push_back(byte_row(FRAME_END, 1'b0, '0));
    directed_rows.push_back(byte_row(FRAME_END, 1'b0, '0));
    directed_rows.push_back(byte_row(FRAME_END, 1'b1, res(1, 0, 0, 255, 255, 0, 0, 0, 0)));
    // back to list mode: index resumes, coordinates held
    directed_rows.push_back(cfg_row(CFG_RECEIVE_MODE, 17'(MODE_LIST)));
    directed_rows.push_back(byte_row(8'hC3, 1'b1, res(0, 0, 0, 255, 255, 0, 0, 1, 1)));

    // random phases: mode, limit, wrap word, item count
    phases[0] = '{MODE_FEEDBACK, 17'd50,     17'd3000,    11'd160};
    phases[1] = '{MODE_FEEDBACK, 17'd0,      17'd1,       11'd160};
    phases[2] = '{MODE_FEEDBACK, 17'd130050, 17'd4095,    11'd180};
    phases[3] = '{MODE_FEEDBACK, 17'd130050, 17'h1F005,   11'd150};
    phases[4] = '{MODE_FEEDBACK, 17'h1FFFF,  17'd0,       11'd140};
    phases[5] = '{MODE_LIST,     17'd900,    17'd3000,    11'd160};
    phases[6] = '{MODE_FEEDBACK, 17'd200,    17'd4,       11'd170};
    phases[7] = '{MODE_LIST,     17'd1000,   17'd2,       11'd150};
    phases[8] = '{MODE_FEEDBACK, 17'd1000,   17'd2,       11'd150};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        settle();
        program_reg(row.idx, row.data);
      end else begin
        send_byte(row.rx_byte, row.typed, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      // upper bits of the mode word are don't-care
      program_reg(CFG_RECEIVE_MODE, {16'($urandom), phases[p].mode});
      program_reg(CFG_NEAR_LIMIT_SQ, phases[p].limit);
      program_reg(CFG_NEAR_WRAP, phases[p].wrap_word);
      if (p == 2) hold_at_item = bytes_sent + 40;
      if (phases[p].mode == MODE_LIST) begin
        repeat (int'(phases[p].n_items)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        run_feedback(int'(phases[p].n_items));
      end
    end

    // drain and let the pipeline go quiet
    @(negedge clk_i) byte_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected result items never arrived", pending_results.size());
    end
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes over %0d phases, %0d results: %0d frames, %0d list writes",
             bytes_sent, NUM_PHASES, results_seen, frames_seen, list_seen);
    $display("long receiver hold-offs: %0d, mismatches: %0d", holds_done, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pfp_pkg.sv
rtl/pfp_if.sv
rtl/pfp_dist.sv
rtl/pfp_proc.sv
rtl/point_frame_parser_proximity_unit.sv
verif/tb.sv
